/* design/auto_summing_fifo_unit_macros.svh */
// Assertion macros for the auto-summing FIFO unit.
// Included by modules that assert; relies on clk and rst_n in scope.
`ifndef AUTO_SUMMING_FIFO_UNIT_MACROS_SVH
`define AUTO_SUMMING_FIFO_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define ASF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define ASF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/asf_pkg.sv */
// Shared types and constants for the auto-summing FIFO unit.
// No dependencies; used by asf_cell and auto_summing_fifo_unit.
`timescale 1ns / 1ps
`default_nettype none

package asf_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 5;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] value;
  } asf_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic                     read_empty;
    logic [CNT_W-1:0]         match_count;
    logic [CNT_W-1:0]         fill_level;
  } asf_out_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic shift;       // move words one cell toward the head
    logic capture;     // latch compare result into the match flag
    logic flag_shift;  // move match flags one cell toward the head
  } asf_cell_ctl_t;

endpackage

`default_nettype wire

/* design/auto_summing_fifo_unit.sv */
// Auto-summing FIFO: write, read, an unused opcode and a count on an empty FIFO give
// the result strobe in the cycle after transfer with busy low, so one such operation can
// follow every cycle. A count on a non-empty FIFO walks the match flags down the cell
// chain: busy for the walk, result strobe registered after its last step. Results cannot be
// stalled by the receiver. Reset (rst_n, synchronous) empties the FIFO, sets capacity
// to DEPTH (at most 31) and empty_value to zero; cell contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module auto_summing_fifo_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // command channel
  input  wire logic             start,
  output logic                  busy,
  input  wire asf_pkg::asf_in_t in_payload,
  // result channel
  output logic                  out_strobe,
  output asf_pkg::asf_out_t     out_payload,
  // configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  `include "auto_summing_fifo_unit_macros.svh"

  localparam int CNT_W  = asf_pkg::CNT_W;
  localparam int WORD_W = asf_pkg::WORD_W;
  localparam int CAP_MAX = (DEPTH > 31) ? 31 : DEPTH;
  localparam int NCELL   = CAP_MAX;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_EMPTY    = 1'b1;

  typedef enum logic {ST_IDLE, ST_COUNT} state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [CNT_W-1:0]         capacity_r, capacity_nxt;
  logic signed [WORD_W-1:0] empty_value_r, empty_value_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]         acc_r, acc_nxt;
  logic                     out_strobe_r, out_strobe_nxt;
  asf_pkg::asf_out_t        out_r, out_nxt;

  asf_pkg::asf_cell_ctl_t   ctl;
  logic [NCELL-1:0]         load_a;
  logic [NCELL-1:0]         valid_a;
  logic [NCELL-1:0]         flag_a;
  logic [NCELL-1:0]         next_flag_a;
  logic signed [WORD_W-1:0] word_a      [NCELL];
  logic signed [WORD_W-1:0] next_word_a [NCELL];
  logic signed [WORD_W-1:0] load_word_a [NCELL];

  logic                     accept;
  logic                     cfg_wr;
  logic                     merge;
  logic [CNT_W-1:0]         wr_idx;
  logic [CNT_W-1:0]         cap_wr;
  logic signed [WORD_W-1:0] merge_sum;

  logic                     count_go;
  logic                     walk_last;
  logic                     empty_rd;
  logic                     empty_flagged;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state_r != ST_IDLE);

  // Merge when full: head absorbs the next entry (or the new word at capacity one)
  assign merge  = (fill_r >= capacity_r);
  assign wr_idx = merge ? (fill_r - CNT_W'(1)) : fill_r;
  assign merge_sum = word_a[0] +
                     ((fill_r >= CNT_W'(2)) ? next_word_a[0] : in_payload.value);

  // Cell chain
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == NCELL - 1) begin : g_tail
      assign next_word_a[i] = '0;
      assign next_flag_a[i] = 1'b0;
    end else begin : g_link
      assign next_word_a[i] = word_a[i+1];
      assign next_flag_a[i] = flag_a[i+1];
    end

    asf_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load      (load_a[i]),
      .load_word (load_word_a[i]),
      .next_word (next_word_a[i]),
      .next_flag (next_flag_a[i]),
      .key       (in_payload.value),
      .valid     (valid_a[i]),
      .word      (word_a[i]),
      .flag      (flag_a[i])
    );
  end

  // Per-cell load select and occupancy mask
  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      valid_a[i]     = (CNT_W'(i) < fill_r);
      load_a[i]      = 1'b0;
      load_word_a[i] = in_payload.value;
      if (accept && (in_payload.opcode == asf_pkg::OP_WRITE)) begin
        if (merge && (i == 0)) begin
          load_a[i]      = 1'b1;
          load_word_a[i] = merge_sum;
        end else if (wr_idx == CNT_W'(i)) begin
          load_a[i] = 1'b1;
        end
      end
    end
  end

  // Clamp a capacity write into 1..CAP_MAX
  always_comb begin
    cap_wr = pwdata[CNT_W-1:0];
    if (cap_wr == '0) begin
      cap_wr = CNT_W'(1);
    end else if (cap_wr > CNT_W'(CAP_MAX)) begin
      cap_wr = CNT_W'(CAP_MAX);
    end
  end

  // Sequencer: operations, count walk and configuration writes
  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    capacity_nxt    = capacity_r;
    empty_value_nxt = empty_value_r;
    rem_nxt         = rem_r;
    acc_nxt         = acc_r;
    out_strobe_nxt  = 1'b0;
    out_nxt         = out_r;
    ctl             = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt             = '0;
          out_strobe_nxt      = 1'b1;
          out_nxt.fill_level  = fill_r;
          unique case (in_payload.opcode)
            asf_pkg::OP_WRITE: begin
              ctl.shift = merge;
              if (!merge) begin
                fill_nxt = fill_r + CNT_W'(1);
              end
              out_nxt.fill_level = merge ? fill_r : (fill_r + CNT_W'(1));
            end
            asf_pkg::OP_READ: begin
              if (fill_r == '0) begin
                out_nxt.read_value = empty_value_r;
                out_nxt.read_empty = 1'b1;
              end else begin
                ctl.shift          = 1'b1;
                fill_nxt           = fill_r - CNT_W'(1);
                out_nxt.read_value = word_a[0];
                out_nxt.fill_level = fill_r - CNT_W'(1);
              end
            end
            asf_pkg::OP_COUNT: begin
              ctl.capture = 1'b1;
              if (fill_r != '0) begin
                out_strobe_nxt = 1'b0;
                state_nxt      = ST_COUNT;
                rem_nxt        = fill_r;
                acc_nxt        = '0;
              end
            end
            default: begin
              // unused opcode: report occupancy only
            end
          endcase
        end
      end
      ST_COUNT: begin
        ctl.flag_shift = 1'b1;
        acc_nxt        = acc_r + CNT_W'(flag_a[0]);
        rem_nxt        = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt           = ST_IDLE;
          out_strobe_nxt      = 1'b1;
          out_nxt             = '0;
          out_nxt.match_count = acc_r + CNT_W'(flag_a[0]);
          out_nxt.fill_level  = fill_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register transfer on the configuration port; capacity is taken only while empty
    if (cfg_wr) begin
      if (paddr[2] == REG_EMPTY) begin
        empty_value_nxt = pwdata;
      end else if (fill_r == '0) begin
        capacity_nxt = cap_wr;
      end
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fill_r        <= '0;
      capacity_r    <= CNT_W'(CAP_MAX);
      empty_value_r <= '0;
      rem_r         <= '0;
      acc_r         <= '0;
      out_strobe_r  <= 1'b0;
      out_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      fill_r        <= fill_nxt;
      capacity_r    <= capacity_nxt;
      empty_value_r <= empty_value_nxt;
      rem_r         <= rem_nxt;
      acc_r         <= acc_nxt;
      out_strobe_r  <= out_strobe_nxt;
      out_r         <= out_nxt;
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_r;

  // Register readback
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CNT_W){1'b0}}, capacity_r}
                                             : empty_value_r;

  // Conditions watched by the checks below
  assign count_go      = accept && (in_payload.opcode == asf_pkg::OP_COUNT) && (fill_r != '0);
  assign walk_last     = (state_r == ST_COUNT) && (rem_r == CNT_W'(1));
  assign empty_rd      = accept && (in_payload.opcode == asf_pkg::OP_READ) && (fill_r == '0);
  assign empty_flagged = out_strobe && out_payload.read_empty && (fill_r == '0);

  `ASF_ASSERT_IMP(a_fill_le_cap, 1'b1, fill_r <= capacity_r, "fill exceeds capacity")
  `ASF_ASSERT_NXT(a_count_busy, count_go, busy && !out_strobe, "count did not enter walk")
  `ASF_ASSERT_NXT(a_count_done, walk_last, out_strobe && !busy, "count walk did not finish")
  `ASF_ASSERT_NXT(a_empty_read, empty_rd, empty_flagged, "empty read not flagged")

endmodule

`default_nettype wire

/* design/asf_cell.sv */
// One storage cell of the FIFO chain: a word and a match flag.
// Depends on asf_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module asf_cell (
  input  wire logic                            clk,
  input  wire asf_pkg::asf_cell_ctl_t          ctl,
  input  wire logic                            load,
  input  wire logic signed [asf_pkg::WORD_W-1:0] load_word,
  input  wire logic signed [asf_pkg::WORD_W-1:0] next_word,
  input  wire logic                            next_flag,
  input  wire logic signed [asf_pkg::WORD_W-1:0] key,
  input  wire logic                            valid,
  output logic signed [asf_pkg::WORD_W-1:0]    word,
  output logic                                 flag
);

  logic signed [asf_pkg::WORD_W-1:0] word_r;
  logic                              flag_r;

  // Load a new word, or take the neighbor's word on a shift
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= load_word;
    end else if (ctl.shift) begin
      word_r <= next_word;
    end
  end

  // Capture the compare result, then hand flags toward the head
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      flag_r <= valid && (word_r == key);
    end else if (ctl.flag_shift) begin
      flag_r <= next_flag;
    end
  end

  assign word = word_r;
  assign flag = flag_r;

endmodule

`default_nettype wire
